/* sv/gtt_pkg.sv */
package gtt_pkg;

  // vertex and triangle layout, element [v][c] at bit (3*v+c)*16
  typedef logic [15:0] coord_t;
  typedef coord_t [2:0] vtx_t;
  typedef vtx_t [2:0] corners_t;

  // one leaf triangle in flight between front and back
  typedef struct packed {
    logic     last;
    corners_t corners;
  } leaf_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // register indexes
  localparam logic CFG_DEPTH  = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  // child selection codes
  localparam logic [1:0] CHILD_CORNER0 = 2'd0;
  localparam logic [1:0] CHILD_CORNER1 = 2'd1;
  localparam logic [1:0] CHILD_CORNER2 = 2'd2;
  localparam logic [1:0] CHILD_MIDDLE  = 2'd3;

  localparam logic [1:0] DEPTH_RESET  = 2'd3;
  localparam logic [14:0] RADIUS_RESET = 15'd13107;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SPLIT,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_MUL1,
    N_MUL2,
    N_ITER,
    N_NEXT,
    N_DONE
  } norm_state_e;

  // floored midpoint: 17-bit sum shifted right arithmetically
  function automatic coord_t mid(coord_t a, coord_t b);
    logic [16:0] s;
    s = {a[15], a} + {b[15], b};
    return s[16:1];
  endfunction

  // cut a triangle and keep one of its four children
  function automatic corners_t split(corners_t t, logic [1:0] child);
    vtx_t     m01, m12, m20;
    corners_t n;
    for (int i = 0; i < 3; i++) begin
      m01[i] = mid(t[0][i], t[1][i]);
      m12[i] = mid(t[1][i], t[2][i]);
      m20[i] = mid(t[2][i], t[0][i]);
    end
    case (child)
      CHILD_CORNER0: begin n[0] = t[0]; n[1] = m01; n[2] = m20; end
      CHILD_CORNER1: begin n[0] = t[1]; n[1] = m12; n[2] = m01; end
      CHILD_CORNER2: begin n[0] = t[2]; n[1] = m20; n[2] = m12; end
      default:       begin n[0] = m01;  n[1] = m12; n[2] = m20; end
    endcase
    return n;
  endfunction

endpackage

/* sv/gtt_front.sv */
module gtt_front #(
  parameter int unsigned MAX_DEPTH = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        depth_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gtt_pkg::corners_t in_corners_i,
  output logic              push_o,
  output gtt_pkg::leaf_t    push_data_o,
  input  logic              full_i
);

  localparam int unsigned KW = 2 * MAX_DEPTH;

  gtt_pkg::front_state_e state_q, state_d;
  gtt_pkg::corners_t     in_q, cur_q;
  logic [KW-1:0]         k_q;
  logic [1:0]            lvl_q, depth_q, depth_eff;
  logic [2:0]            sh;
  logic [1:0]            child;
  logic [KW:0]           full_cnt;
  logic                  last;
  logic                  accept;

  assign depth_eff = (depth_i > 2'(MAX_DEPTH)) ? 2'(MAX_DEPTH) : depth_i;
  assign accept    = in_valid_i && in_ready_o;

  // child index of the current level, taken from the leaf counter
  assign sh    = {depth_q - 2'd1 - lvl_q, 1'b0};
  assign child = 2'(k_q >> sh);

  // last leaf once the counter reaches 4^depth - 1
  assign full_cnt = (KW+1)'(1) << {depth_q, 1'b0};
  assign last     = ({1'b0, k_q} == full_cnt - (KW+1)'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtt_pkg::F_IDLE:  if (accept) state_d = (depth_eff == 2'd0) ? gtt_pkg::F_PUSH
                                                                  : gtt_pkg::F_SPLIT;
      gtt_pkg::F_SPLIT: if (lvl_q == depth_q - 2'd1) state_d = gtt_pkg::F_PUSH;
      gtt_pkg::F_PUSH:  if (!full_i) state_d = last ? gtt_pkg::F_IDLE
                          : ((depth_q == 2'd0) ? gtt_pkg::F_PUSH : gtt_pkg::F_SPLIT);
      default: state_d = gtt_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o               = (state_q == gtt_pkg::F_IDLE);
    push_o                   = (state_q == gtt_pkg::F_PUSH) && !full_i;
    push_data_o.corners      = cur_q;
    push_data_o.last         = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtt_pkg::F_IDLE;
      k_q     <= '0;
      lvl_q   <= '0;
      depth_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        k_q     <= '0;
        lvl_q   <= '0;
        depth_q <= depth_eff;
      end else if (state_q == gtt_pkg::F_SPLIT) begin
        lvl_q <= lvl_q + 2'd1;
      end else if (push_o) begin
        k_q   <= k_q + KW'(1);
        lvl_q <= '0;
      end
    end
  end

  // triangle registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q  <= in_corners_i;
      cur_q <= in_corners_i;
    end else if (state_q == gtt_pkg::F_SPLIT) begin
      cur_q <= gtt_pkg::split(cur_q, child);
    end else if (push_o) begin
      cur_q <= in_q;
    end
  end

endmodule

/* sv/gtt_fifo.sv */
module gtt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gtt_pkg::leaf_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output gtt_pkg::leaf_t data_o
);

  gtt_pkg::leaf_t                  mem_q [gtt_pkg::FIFO_DEPTH];
  logic [gtt_pkg::FIFO_AW-1:0]     wptr_q, rptr_q;
  logic [gtt_pkg::FIFO_AW:0]       cnt_q;

  assign full_o  = (cnt_q == (gtt_pkg::FIFO_AW+1)'(gtt_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (gtt_pkg::FIFO_AW+1)'(push_i) - (gtt_pkg::FIFO_AW+1)'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

/* sv/gtt_norm.sv */
module gtt_norm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [14:0]       radius_i,
  input  logic              leaf_valid_i,
  input  gtt_pkg::leaf_t    leaf_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gtt_pkg::corners_t out_corners_o,
  output logic              out_zero_o,
  output logic              out_last_o
);

  gtt_pkg::norm_state_e state_q, state_d;
  gtt_pkg::leaf_t       leaf_q;
  gtt_pkg::corners_t    res_q;
  logic                 zero_q;
  logic [1:0]           vi_q, ci_q;
  logic [31:0]          s_q;
  logic [30:0]          num_q;
  logic [61:0]          num2_q;
  logic [63:0]          p_q;
  logic [46:0]          qs_q;
  logic [14:0]          q_q;
  logic [3:0]           b_q;
  logic                 out_valid_q;

  gtt_pkg::coord_t      c;
  logic signed [31:0]   sq;
  logic [31:0]          s_next;
  logic [15:0]          mag;
  logic [63:0]          t_sum;
  logic                 take;
  logic                 out_free;

  assign c      = leaf_q.corners[vi_q][ci_q];
  assign sq     = $signed(c) * $signed(c);
  assign s_next = s_q + 32'(sq);
  assign mag    = c[15] ? 16'(~c + 16'd1) : c;

  // trial square of the next candidate bit, built from running sums
  assign t_sum = p_q + ({17'b0, qs_q} << (b_q + 4'd1)) + ({32'b0, s_q} << {b_q, 1'b0});
  assign take  = (t_sum <= {2'b0, num2_q});

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtt_pkg::N_IDLE: if (leaf_valid_i) state_d = gtt_pkg::N_SQ;
      gtt_pkg::N_SQ: begin
        if (ci_q == 2'd2) begin
          if (s_next != '0)       state_d = gtt_pkg::N_MUL1;
          else if (vi_q == 2'd2)  state_d = gtt_pkg::N_DONE;
        end
      end
      gtt_pkg::N_MUL1: state_d = gtt_pkg::N_MUL2;
      gtt_pkg::N_MUL2: state_d = gtt_pkg::N_ITER;
      gtt_pkg::N_ITER: if (b_q == 4'd0) state_d = gtt_pkg::N_NEXT;
      gtt_pkg::N_NEXT: begin
        if (ci_q != 2'd2)       state_d = gtt_pkg::N_MUL1;
        else if (vi_q == 2'd2)  state_d = gtt_pkg::N_DONE;
        else                    state_d = gtt_pkg::N_SQ;
      end
      gtt_pkg::N_DONE: if (out_free) state_d = gtt_pkg::N_IDLE;
      default: state_d = gtt_pkg::N_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o         = (state_q == gtt_pkg::N_IDLE) && leaf_valid_i;
    out_valid_o   = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gtt_pkg::N_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == gtt_pkg::N_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)                       out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gtt_pkg::N_IDLE: begin
        leaf_q <= leaf_i;
        zero_q <= 1'b0;
        vi_q   <= '0;
        ci_q   <= '0;
        s_q    <= '0;
      end
      gtt_pkg::N_SQ: begin
        s_q <= s_next;
        if (ci_q == 2'd2) begin
          ci_q <= '0;
          if (s_next == '0) begin
            res_q[vi_q] <= '0;
            zero_q      <= 1'b1;
            vi_q        <= vi_q + 2'd1;
            s_q         <= '0;
          end
        end else begin
          ci_q <= ci_q + 2'd1;
        end
      end
      gtt_pkg::N_MUL1: num_q <= 31'(mag) * 31'(radius_i);
      gtt_pkg::N_MUL2: begin
        num2_q <= num_q * num_q;
        p_q    <= '0;
        qs_q   <= '0;
        q_q    <= '0;
        b_q    <= 4'd14;
      end
      gtt_pkg::N_ITER: begin
        if (take) begin
          p_q  <= t_sum;
          qs_q <= qs_q + (47'(s_q) << b_q);
          q_q  <= q_q | (15'd1 << b_q);
        end
        b_q <= b_q - 4'd1;
      end
      gtt_pkg::N_NEXT: begin
        res_q[vi_q][ci_q] <= c[15] ? 16'(~{1'b0, q_q} + 16'd1) : {1'b0, q_q};
        if (ci_q == 2'd2) begin
          ci_q <= '0;
          vi_q <= vi_q + 2'd1;
          s_q  <= '0;
        end else begin
          ci_q <= ci_q + 2'd1;
        end
      end
      gtt_pkg::N_DONE: begin
        if (out_free) begin
          out_corners_o <= res_q;
          out_zero_o    <= zero_q;
          out_last_o    <= leaf_q.last;
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/geodesic_triangle_tessellator.sv */
// the normalizer takes one leaf triangle at a time: per vertex it sums the squared length,
//   then runs each coordinate through the bit-serial 15-step normalizer loop;
//   a zero-length vertex skips the loop, 4^depth leaves per input triangle
// the subdivision front runs ahead by up to four leaves through the queue
// reset: asynchronous active low, depth returns to 3 and radius to 13107
module geodesic_triangle_tessellator #(
  parameter int unsigned MAX_DEPTH = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [14:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // in_ax, in_ay, in_az, in_bx .. in_cz
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,  // out_ax, out_ay, out_az, out_bx .. out_cz
  output logic         m_axis_tuser,  // zero_length
  output logic         m_axis_tlast
);

  logic [1:0]        depth_q;
  logic [14:0]       radius_q;
  logic              push, full, pop, leaf_valid;
  gtt_pkg::leaf_t    push_data, leaf;
  gtt_pkg::corners_t out_corners;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= gtt_pkg::DEPTH_RESET;
      radius_q <= gtt_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gtt_pkg::CFG_DEPTH:  depth_q  <= cfg_data_i[1:0];
        default:             radius_q <= cfg_data_i;
      endcase
    end
  end

  gtt_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .depth_i      (depth_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_corners_i (s_axis_tdata),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  gtt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (leaf_valid),
    .data_o  (leaf)
  );

  gtt_norm u_norm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radius_i      (radius_q),
    .leaf_valid_i  (leaf_valid),
    .leaf_i        (leaf),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_corners_o (out_corners),
    .out_zero_o    (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = out_corners;

endmodule

/* sv/gtt_checker.sv */
module gtt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // no result right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid in reset");

  // zero-length flag needs an all-zero vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[47:0] == 48'd0)
      || (m_axis_tdata[95:48] == 48'd0) || (m_axis_tdata[143:96] == 48'd0))
    else $error("zero flag without zero vertex");

  // four projected coordinates (ax, ay, cx, cz) stay inside the symmetric range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'h8000) && (m_axis_tdata[31:16] != 16'h8000)
      && (m_axis_tdata[111:96] != 16'h8000) && (m_axis_tdata[143:128] != 16'h8000))
    else $error("coordinate out of range");

endmodule

bind geodesic_triangle_tessellator gtt_checker u_gtt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* bench/geodesic_triangle_tessellator_tb.sv */
module geodesic_triangle_tessellator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [15:0] scoord_t;

  // one leaf triangle as the block should deliver it
  typedef struct {
    logic [143:0] coords;
    logic         zero_len;
    logic         last;
  } leaf_exp_t;

  // scoreboard: tessellates accepted triangles and checks delivered leaves
  class leaf_scoreboard;
    int unsigned depth_reg;
    int unsigned radius_reg;
    leaf_exp_t   pending_leaves[$];
    int          errors;
    int          leaves_seen;
    int          zero_seen;

    function void reset_regs();
      depth_reg  = 3;
      radius_reg = 13107;
    endfunction

    function void write_reg(logic idx, logic [14:0] val);
      if (idx == gtt_pkg::CFG_DEPTH) depth_reg = val[1:0];
      else radius_reg = val;
    endfunction

    static function int floor_mid(int p, int q);
      return (p + q) >>> 1;
    endfunction

    // project one vertex onto the sphere; returns 1 on zero length
    function bit project_vertex(ref int v[3]);
      longint unsigned s, mag, num2, q, cand;
      s = 0;
      for (int i = 0; i < 3; i++) s += longint'(v[i]) * longint'(v[i]);
      if (s == 0) begin
        for (int i = 0; i < 3; i++) v[i] = 0;
        return 1;
      end
      for (int i = 0; i < 3; i++) begin
        mag  = (v[i] < 0) ? -v[i] : v[i];
        num2 = (mag * radius_reg) * (mag * radius_reg);
        q = 0;
        for (int b = 14; b >= 0; b--) begin
          cand = q | (64'd1 << b);
          if (cand * cand * s <= num2) q = cand;
        end
        if (q > 32767) q = 32767;
        v[i] = (v[i] < 0) ? -int'(q) : int'(q);
      end
      return 0;
    endfunction

    // note an accepted triangle and queue all its leaves
    function void note_triangle(logic [143:0] data);
      int tri_in[3][3], t[3][3], n[3][3], m01[3], m12[3], m20[3], v[3];
      int unsigned cnt, child;
      bit zl;
      leaf_exp_t e;
      for (int a = 0; a < 3; a++)
        for (int c = 0; c < 3; c++)
          tri_in[a][c] = scoord_t'(data[(3*a+c)*16 +: 16]);
      cnt = 1 << (2 * depth_reg);
      for (int k = 0; k < cnt; k++) begin
        t = tri_in;
        for (int l = 0; l < depth_reg; l++) begin
          child = (k >> (2 * (depth_reg - 1 - l))) & 3;
          for (int i = 0; i < 3; i++) begin
            m01[i] = floor_mid(t[0][i], t[1][i]);
            m12[i] = floor_mid(t[1][i], t[2][i]);
            m20[i] = floor_mid(t[2][i], t[0][i]);
            case (child)
              0: begin n[0][i] = t[0][i]; n[1][i] = m01[i]; n[2][i] = m20[i]; end
              1: begin n[0][i] = t[1][i]; n[1][i] = m12[i]; n[2][i] = m01[i]; end
              2: begin n[0][i] = t[2][i]; n[1][i] = m20[i]; n[2][i] = m12[i]; end
              default: begin n[0][i] = m01[i]; n[1][i] = m12[i]; n[2][i] = m20[i]; end
            endcase
          end
          t = n;
        end
        zl = 0;
        for (int a = 0; a < 3; a++) begin
          for (int c = 0; c < 3; c++) v[c] = t[a][c];
          if (project_vertex(v)) zl = 1;
          for (int c = 0; c < 3; c++) e.coords[(3*a+c)*16 +: 16] = v[c][15:0];
        end
        e.zero_len = zl;
        e.last     = (k == cnt - 1);
        pending_leaves.push_back(e);
      end
    endfunction

    // compare one delivered leaf with the oldest expected one
    function void check_leaf(logic [143:0] data, logic zl, logic last);
      leaf_exp_t e;
      leaves_seen++;
      if (zl) zero_seen++;
      if (pending_leaves.size() == 0) begin
        $display("%0t: unexpected leaf %h zero=%b last=%b", $time, data, zl, last);
        errors++;
        return;
      end
      e = pending_leaves.pop_front();
      for (int f = 0; f < 9; f++)
        if (data[f*16 +: 16] !== e.coords[f*16 +: 16]) begin
          $display("%0t: coord %0d expected %0d actual %0d", $time, f,
                   scoord_t'(e.coords[f*16 +: 16]), scoord_t'(data[f*16 +: 16]));
          errors++;
        end
      if (zl !== e.zero_len) begin
        $display("%0t: zero_length expected %b actual %b", $time, e.zero_len, zl);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  localparam int HOLD_LEN = 3000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic         cfg_index_i = 0;
  logic [14:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  leaf_scoreboard sb = new();
  int  hold_cnt = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  sink_gap = 0;
  int  triangles_sent = 0;
  bit  sink_on = 0;

  geodesic_triangle_tessellator dut (.*);

  always #5 clk_i = ~clk_i;

  // random gap length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // output side: random gaps, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!sink_on) m_axis_tready <= 0;
    else if (hold_req && !hold_done) begin
      m_axis_tready <= 0;
      hold_cnt      <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN - 1) hold_done <= 1;
    end else if (sink_gap > 0) begin
      m_axis_tready <= 0;
      sink_gap      <= sink_gap - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 0;
      sink_gap      <= gap_len();
    end else m_axis_tready <= 1;
  end

  // check every leaf transfer
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_leaf(m_axis_tdata, m_axis_tuser, m_axis_tlast);

  task automatic write_cfg(logic idx, logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
  endtask

  // offer one triangle and wait for its transfer
  task automatic send_triangle(logic [143:0] data, bit use_gap);
    int g;
    g = use_gap ? gap_len() : 0;
    repeat (g + 1) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_triangle(data);
    triangles_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  // wait until every expected leaf is out, then let the block settle
  task automatic drain();
    while (sb.pending_leaves.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic [143:0] pack_tri(int v[9]);
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[i*16 +: 16] = v[i][15:0];
    return d;
  endfunction

  function automatic int rnd_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 8000) - 4000;
      default: return ($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 200) - 100;
    endcase
  endfunction

  initial begin
    int v[9];
    int unsigned dsel;
    sb.reset_regs();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  <= 1;
    sink_on <= 1;

    // directed: reset settings, extremes, zero vertices, degenerate triangles
    v = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    send_triangle(pack_tri(v), 0);
    drain();
    write_cfg(gtt_pkg::CFG_DEPTH, 15'd0);
    write_cfg(gtt_pkg::CFG_RADIUS, 15'd32767);
    v = '{32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0};
    send_triangle(pack_tri(v), 0);
    v = '{-32768, 0, 0, 0, -32768, 0, 0, 0, 32767};
    send_triangle(pack_tri(v), 0);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_triangle(pack_tri(v), 0);
    v = '{1, 0, 0, 0, -1, 0, 0, 0, 1};
    send_triangle(pack_tri(v), 0);
    drain();
    write_cfg(gtt_pkg::CFG_RADIUS, 15'd0);
    v = '{100, -200, 300, -32768, 32767, 5, 7, 7, 7};
    send_triangle(pack_tri(v), 0);
    drain();
    write_cfg(gtt_pkg::CFG_DEPTH, 15'd1);
    write_cfg(gtt_pkg::CFG_RADIUS, 15'd16384);
    // opposite vertices meet at the origin in midpoints
    v = '{1, 1, 1, -1, -1, -1, 20000, -3, 9};
    send_triangle(pack_tri(v), 0);
    v = '{32767, -32768, 32767, -32768, 32767, -32768, 0, 1, -1};
    send_triangle(pack_tri(v), 0);
    drain();
    write_cfg(gtt_pkg::CFG_DEPTH, 15'd2);
    v = '{-16384, 0, 0, 16384, 0, 0, 0, 16384, 0};
    send_triangle(pack_tri(v), 0);
    drain();
    write_cfg(gtt_pkg::CFG_DEPTH, 15'h7ffd);
    write_cfg(gtt_pkg::CFG_RADIUS, 15'd13107);
    v = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
    send_triangle(pack_tri(v), 0);

    // pressure: hold the output off while triangles keep coming
    hold_req = 1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 9; j++) v[j] = rnd_coord(2);
      send_triangle(pack_tri(v), 0);
    end
    drain();

    // random phases over several settings; mostly shallow depths
    for (int ph = 0; ph < 10; ph++) begin
      dsel = $urandom_range(0, 9);
      write_cfg(gtt_pkg::CFG_DEPTH,
                dsel < 5 ? 15'd0 : dsel < 8 ? 15'd1 : dsel < 9 ? 15'd2 : 15'd3);
      case (ph % 4)
        0: write_cfg(gtt_pkg::CFG_RADIUS, 15'($urandom_range(0, 32767)));
        1: write_cfg(gtt_pkg::CFG_RADIUS, 15'd32767);
        2: write_cfg(gtt_pkg::CFG_RADIUS, 15'($urandom_range(0, 3)));
        default: write_cfg(gtt_pkg::CFG_RADIUS, 15'd13107);
      endcase
      for (int i = 0; i < 28; i++) begin
        for (int j = 0; j < 9; j++) v[j] = rnd_coord(i % 3);
        if ($urandom_range(0, 9) == 0) begin
          dsel = $urandom_range(0, 2);
          v[3*dsel] = 0; v[3*dsel+1] = 0; v[3*dsel+2] = 0;
        end
        send_triangle(pack_tri(v), 1);
      end
      drain();
    end

    $display("covered %0d triangles, %0d leaves, %0d with a zero-length vertex",
             triangles_sent, sb.leaves_seen, sb.zero_seen);
    $display("depths 0 to 3, radius extremes, long output hold-off with input backpressure");
    if (sb.errors == 0 && sb.pending_leaves.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #300ms;
    $display("simulation failed");
    $finish;
  end
endmodule
